@@ rtl/core/bspl_pkg.sv @@
`timescale 1ns / 1ps
// shared constants, codes and controller/datapath handshake structs
// for the b-spline curve point evaluator; no dependencies
package bspl_pkg;

    // default sizing
    localparam int MAX_POINTS_DEF = 64;
    localparam int MAX_DEGREE_DEF = 7;

    // configuration port
    localparam int CFG_WIDTH = 7;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMPED     = 2'd2;
    localparam logic [2:0] DEGREE_RST      = 3'd3;
    localparam logic [6:0] POINT_COUNT_RST = 7'd4;

    // command codes
    localparam logic [1:0] CMD_WR_KNOT  = 2'd0;
    localparam logic [1:0] CMD_WR_POINT = 2'd1;
    localparam logic [1:0] CMD_EVAL     = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_DECREASING = 2'd1;
    localparam logic [1:0] STAT_CLAMP      = 2'd2;
    localparam logic [1:0] STAT_FEW_POINTS = 2'd3;

    // one in q2.30
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    // controller to datapath commands
    typedef struct packed {
        logic eval_start;
        logic scan_issue;
        logic decide;
        logic term_begin;
        logic rd0;
        logic rd1;
        logic rd2;
        logic prep;
        logic mul;
        logic div_step;
        logic tacc;
        logic tstore;
        logic mmul;
        logic macc;
        logic mskip;
        logic out;
    } bspl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_last;
        logic go_basis;
        logic p_zero;
        logic j_ok;
        logic term_zero;
        logic div_last;
        logic more_b;
        logic k_last;
        logic d_last;
        logic i_ok;
        logic m_last;
    } bspl_sts_t;

endpackage

@@ rtl/core/bspl_ctrl.sv @@
`timescale 1ns / 1ps
// sequencer for knot scan, cox-de boor basis table and point accumulation
// depends on bspl_pkg
module bspl_ctrl
    import bspl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] command,
    output logic       busy,
    output bspl_cmd_t  cmd,
    input  bspl_sts_t  sts
);

    typedef enum logic [16:0] {
        S_IDLE      = 17'h00001,
        S_SCAN      = 17'h00002,
        S_SCAN_WAIT = 17'h00004,
        S_DECIDE    = 17'h00008,
        S_TCHECK    = 17'h00010,
        S_RD0       = 17'h00020,
        S_RD1       = 17'h00040,
        S_RD2       = 17'h00080,
        S_PREP      = 17'h00100,
        S_MUL       = 17'h00200,
        S_DIV       = 17'h00400,
        S_TACC      = 17'h00800,
        S_TSTORE    = 17'h01000,
        S_MCHECK    = 17'h02000,
        S_MMUL      = 17'h04000,
        S_MACC      = 17'h08000,
        S_OUT       = 17'h10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && command == CMD_EVAL)
                begin
                    cmd.eval_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (!sts.go_basis)
                begin
                    state_next = S_OUT;
                end
                else if (sts.p_zero)
                begin
                    state_next = S_MCHECK;
                end
                else
                begin
                    state_next = S_TCHECK;
                end
            end
            S_TCHECK:
            begin
                cmd.term_begin = 1'b1;
                state_next     = sts.j_ok ? S_RD0 : S_TSTORE;
            end
            S_RD0:
            begin
                cmd.rd0    = 1'b1;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.rd1    = 1'b1;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                cmd.rd2    = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = sts.term_zero ? S_TACC : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_TACC;
                end
            end
            S_TACC:
            begin
                cmd.tacc   = 1'b1;
                state_next = sts.more_b ? S_RD0 : S_TSTORE;
            end
            S_TSTORE:
            begin
                cmd.tstore = 1'b1;
                state_next = (sts.k_last && sts.d_last) ? S_MCHECK : S_TCHECK;
            end
            S_MCHECK:
            begin
                if (sts.i_ok)
                begin
                    state_next = S_MMUL;
                end
                else
                begin
                    cmd.mskip  = 1'b1;
                    state_next = sts.m_last ? S_OUT : S_MCHECK;
                end
            end
            S_MMUL:
            begin
                cmd.mmul   = 1'b1;
                state_next = S_MACC;
            end
            S_MACC:
            begin
                cmd.macc   = 1'b1;
                state_next = sts.m_last ? S_OUT : S_MCHECK;
            end
            S_OUT:
            begin
                cmd.out    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/bspl_dp.sv @@
`timescale 1ns / 1ps
// datapath: config registers, knot and point memories, knot scan,
// basis row, radix-2 divider and point multiply-accumulate; uses bspl_pkg
module bspl_dp
    import bspl_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [1:0]            command,
    input  logic [6:0]            entry_index,
    input  logic [31:0]           knot_value,
    input  logic signed [31:0]    point_x,
    input  logic signed [31:0]    point_y,
    input  logic [31:0]           param_u,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_WIDTH-1:0]  cfg_data,
    input  bspl_cmd_t             cmd,
    output bspl_sts_t             sts,
    output logic                  done,
    output logic signed [31:0]    curve_x,
    output logic signed [31:0]    curve_y,
    output logic [1:0]            status
);

    localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 1;
    localparam int ROW_DEPTH  = MAX_DEGREE + 1;
    localparam int KAW        = $clog2(KNOT_DEPTH);
    localparam int PAW        = $clog2(MAX_POINTS);
    localparam int NW         = $clog2(MAX_POINTS + 1);
    localparam int PW         = $clog2(MAX_DEGREE + 1);
    localparam int IW         = KAW + 2;
    localparam int SUM_W      = 40;
    localparam int DIV_STEPS  = 64;
    localparam int DCW        = $clog2(DIV_STEPS);

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] lim_hi;
        logic signed [SUM_W-1:0] lim_lo;
        lim_hi = SUM_W'(32'sh7fff_ffff);
        lim_lo = SUM_W'(32'sh8000_0000);
        if (v > lim_hi)
        begin
            return 32'sh7fff_ffff;
        end
        else if (v < lim_lo)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // configuration registers
    logic [2:0]  degree_reg;
    logic [6:0]  point_count_reg;
    logic        clamped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg      <= DEGREE_RST;
            point_count_reg <= POINT_COUNT_RST;
            clamped_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEGREE:      degree_reg      <= cfg_data[2:0];
                CFG_POINT_COUNT: point_count_reg <= cfg_data[6:0];
                CFG_CLAMPED:     clamped_reg     <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // effective degree and point count
    logic [PW-1:0] p_eff;
    logic [NW-1:0] n_eff;

    always_comb
    begin
        p_eff = (int'(degree_reg) > MAX_DEGREE) ? PW'(MAX_DEGREE) : PW'(degree_reg);
        n_eff = (int'(point_count_reg) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(point_count_reg);
    end

    // memories
    logic [31:0]        knot_mem [KNOT_DEPTH];
    logic signed [31:0] px_mem   [MAX_POINTS];
    logic signed [31:0] py_mem   [MAX_POINTS];
    logic [31:0]        knot_rd_reg;
    logic signed [31:0] px_rd_reg;
    logic signed [31:0] py_rd_reg;

    logic          accept;
    logic          knot_we;
    logic          pt_we;
    logic [KAW-1:0] knot_ra;
    logic [PAW-1:0] pt_ra;

    assign accept  = start && !busy;
    assign knot_we = accept && (command == CMD_WR_KNOT) && (int'(entry_index) < KNOT_DEPTH);
    assign pt_we   = accept && (command == CMD_WR_POINT) && (int'(entry_index) < MAX_POINTS);

    always_ff @(posedge clk)
    begin
        if (knot_we)
        begin
            knot_mem[KAW'(entry_index)] <= knot_value;
        end
        knot_rd_reg <= knot_mem[knot_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            px_mem[PAW'(entry_index)] <= point_x;
            py_mem[PAW'(entry_index)] <= point_y;
        end
        px_rd_reg <= px_mem[pt_ra];
        py_rd_reg <= py_mem[pt_ra];
    end

    // control registers
    logic [KAW-1:0] scan_cnt_reg;
    logic           scan_vld_reg;
    logic           dec_reg;
    logic           clamp_err_reg;
    logic           found_reg;
    logic [KAW-1:0] s_reg;
    logic [PW-1:0]  d_reg;
    logic [PW-1:0]  k_reg;
    logic           side_reg;
    logic [DCW-1:0] div_cnt_reg;
    logic           done_reg;

    // payload registers
    logic [KAW-1:0]        scan_idx_reg;
    logic [31:0]           prev_reg;
    logic [31:0]           u_reg;
    logic [31:0]           k0_reg;
    logic [31:0]           k1_reg;
    logic [31:0]           mb_reg;
    logic [32:0]           mn_reg;
    logic [32:0]           md_reg;
    logic                  neg_reg;
    logic                  zero_reg;
    logic [63:0]           quo_reg;
    logic [32:0]           rem_reg;
    logic signed [33:0]    acc_reg;
    logic signed [31:0]    row_reg  [ROW_DEPTH];
    logic signed [31:0]    next_reg [ROW_DEPTH];
    logic signed [31:0]    row_prev_reg;
    logic signed [63:0]    prod_x_reg;
    logic signed [63:0]    prod_y_reg;
    logic signed [SUM_W-1:0] sum_x_reg;
    logic signed [SUM_W-1:0] sum_y_reg;
    logic [1:0]            status_reg;
    logic signed [31:0]    curve_x_reg;
    logic signed [31:0]    curve_y_reg;

    // index arithmetic
    logic signed [IW-1:0] n_s;
    logic signed [IW-1:0] p_s;
    logic signed [IW-1:0] d_s;
    logic signed [IW-1:0] k_s;
    logic signed [IW-1:0] s_s;
    logic signed [IW-1:0] last_s;
    logic signed [IW-1:0] scan_s;
    logic signed [IW-1:0] pidx_s;
    logic signed [IW-1:0] j_s;
    logic signed [IW-1:0] i_s;
    logic signed [IW-1:0] addr0_s;
    logic signed [IW-1:0] addr1_s;

    assign n_s     = IW'(n_eff);
    assign p_s     = IW'(p_eff);
    assign d_s     = IW'(d_reg);
    assign k_s     = IW'(k_reg);
    assign s_s     = IW'(s_reg);
    assign scan_s  = IW'(scan_cnt_reg);
    assign pidx_s  = IW'(scan_idx_reg);
    assign last_s  = n_s + p_s;
    assign j_s     = s_s - d_s + k_s;
    assign i_s     = s_s - p_s + k_s;
    assign addr0_s = j_s + IW'(side_reg);
    assign addr1_s = j_s + d_s + IW'(side_reg);

    always_comb
    begin
        priority if (cmd.rd0)
        begin
            knot_ra = KAW'(addr0_s);
        end
        else if (cmd.rd1)
        begin
            knot_ra = KAW'(addr1_s);
        end
        else
        begin
            knot_ra = scan_cnt_reg;
        end
    end

    assign pt_ra = PAW'(i_s);

    // knot scan checks
    logic pair_vld;
    logic clamp_pos;
    logic need_a;
    logic need_b;
    logic [1:0] stat_code;

    assign pair_vld  = scan_vld_reg && (scan_idx_reg != '0);
    assign clamp_pos = (pidx_s <= p_s) || (pidx_s >= n_s + 1);
    assign need_a    = (k_reg != '0);
    assign need_b    = (k_reg < d_reg);

    always_comb
    begin
        priority if (dec_reg)
        begin
            stat_code = STAT_DECREASING;
        end
        else if (clamp_err_reg)
        begin
            stat_code = STAT_CLAMP;
        end
        else if (int'(n_eff) < int'(p_eff) + 1)
        begin
            stat_code = STAT_FEW_POINTS;
        end
        else
        begin
            stat_code = STAT_OK;
        end
    end

    // status to controller
    always_comb
    begin
        sts.scan_last = (scan_s == last_s);
        sts.go_basis  = (stat_code == STAT_OK) && found_reg;
        sts.p_zero    = (p_eff == '0);
        sts.j_ok      = (j_s >= 0) && (j_s <= last_s - 1 - d_s);
        sts.term_zero = zero_reg;
        sts.div_last  = &div_cnt_reg;
        sts.more_b    = !side_reg && need_b;
        sts.k_last    = (k_reg == d_reg);
        sts.d_last    = (d_reg == p_eff);
        sts.i_ok      = (i_s >= 0) && (i_s < n_s);
        sts.m_last    = (k_reg == p_eff);
    end

    // scan, loop counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg  <= '0;
            scan_vld_reg  <= 1'b0;
            dec_reg       <= 1'b0;
            clamp_err_reg <= 1'b0;
            found_reg     <= 1'b0;
            s_reg         <= '0;
            d_reg         <= '0;
            k_reg         <= '0;
            side_reg      <= 1'b0;
            div_cnt_reg   <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            scan_vld_reg <= cmd.scan_issue;
            done_reg     <= cmd.out;
            if (cmd.eval_start)
            begin
                scan_cnt_reg  <= '0;
                dec_reg       <= 1'b0;
                clamp_err_reg <= 1'b0;
                found_reg     <= 1'b0;
            end
            else if (cmd.scan_issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            if (pair_vld)
            begin
                if (prev_reg > knot_rd_reg)
                begin
                    dec_reg <= 1'b1;
                end
                if (clamped_reg && clamp_pos && (prev_reg != knot_rd_reg))
                begin
                    clamp_err_reg <= 1'b1;
                end
                if (!found_reg && (prev_reg <= u_reg) && (u_reg < knot_rd_reg))
                begin
                    found_reg <= 1'b1;
                    s_reg     <= scan_idx_reg - 1'b1;
                end
            end
            if (cmd.decide)
            begin
                d_reg <= PW'(1);
                k_reg <= '0;
            end
            if (cmd.term_begin)
            begin
                side_reg <= !need_a;
            end
            if (cmd.tacc && !side_reg && need_b)
            begin
                side_reg <= 1'b1;
            end
            if (cmd.tstore)
            begin
                if (k_reg == d_reg)
                begin
                    k_reg <= '0;
                    d_reg <= d_reg + 1'b1;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            if (cmd.macc || cmd.mskip)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (cmd.mul)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
        end
    end

    // term operand preparation
    logic signed [31:0] base_sel;
    logic signed [31:0] base_neg;
    logic signed [33:0] num_v;
    logic signed [33:0] den_v;
    logic signed [33:0] num_neg;
    logic signed [33:0] den_neg;
    logic [63:0]        prod_full;

    assign base_sel  = side_reg ? row_reg[0] : row_prev_reg;
    assign base_neg  = -base_sel;
    assign num_v     = side_reg ? ({2'b00, k1_reg} - {2'b00, u_reg})
                                : ({2'b00, u_reg} - {2'b00, k0_reg});
    assign den_v     = {2'b00, k1_reg} - {2'b00, k0_reg};
    assign num_neg   = -num_v;
    assign den_neg   = -den_v;
    assign prod_full = {32'b0, mb_reg} * {31'b0, mn_reg};

    // restoring divider step
    logic [33:0] rem_sh;
    logic [33:0] div_ext;
    logic [33:0] rem_diff;
    logic        rem_ge;

    assign rem_sh   = {rem_reg, quo_reg[63]};
    assign div_ext  = {1'b0, md_reg};
    assign rem_ge   = (rem_sh >= div_ext);
    assign rem_diff = rem_sh - div_ext;

    // quotient clamp, sign and saturated sum
    logic               q_big;
    logic [32:0]        q_clamp;
    logic signed [33:0] term_v;
    logic signed [31:0] acc_sat;

    assign q_big   = (|quo_reg[63:32]) || (quo_reg[31:0] > 32'h8000_0000);
    assign q_clamp = q_big ? 33'h0_8000_0000 : {1'b0, quo_reg[31:0]};
    assign term_v  = zero_reg ? '0 : (neg_reg ? -{1'b0, q_clamp} : {1'b0, q_clamp});
    assign acc_sat = sat32({{(SUM_W-34){acc_reg[33]}}, acc_reg});

    // basis row shifted by one
    logic signed [31:0] row_shift [ROW_DEPTH];

    always_comb
    begin
        for (int i = 0; i < ROW_DEPTH - 1; i++)
        begin
            row_shift[i] = row_reg[i + 1];
        end
        row_shift[ROW_DEPTH-1] = '0;
    end

    // point products truncated toward zero by 2^30
    logic signed [63:0] mul_x;
    logic signed [63:0] mul_y;
    logic signed [63:0] bias_x;
    logic signed [63:0] bias_y;
    logic signed [63:0] shx;
    logic signed [63:0] shy;

    assign mul_x  = 64'(row_reg[0]) * 64'(px_rd_reg);
    assign mul_y  = 64'(row_reg[0]) * 64'(py_rd_reg);
    assign bias_x = prod_x_reg + (prod_x_reg[63] ? 64'sd1073741823 : 64'sd0);
    assign bias_y = prod_y_reg + (prod_y_reg[63] ? 64'sd1073741823 : 64'sd0);
    assign shx    = bias_x >>> 30;
    assign shy    = bias_y >>> 30;

    // payload datapath
    always_ff @(posedge clk)
    begin
        if (cmd.eval_start)
        begin
            u_reg     <= param_u;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end
        if (scan_vld_reg)
        begin
            prev_reg <= knot_rd_reg;
        end
        scan_idx_reg <= scan_cnt_reg;
        if (cmd.decide)
        begin
            status_reg   <= stat_code;
            row_reg[0]   <= ONE_Q30;
            row_prev_reg <= '0;
        end
        if (cmd.term_begin)
        begin
            acc_reg <= '0;
        end
        if (cmd.rd1)
        begin
            k0_reg <= knot_rd_reg;
        end
        if (cmd.rd2)
        begin
            k1_reg <= knot_rd_reg;
        end
        if (cmd.prep)
        begin
            mb_reg   <= base_sel[31] ? base_neg : base_sel;
            mn_reg   <= num_v[33] ? num_neg[32:0] : num_v[32:0];
            md_reg   <= den_v[33] ? den_neg[32:0] : den_v[32:0];
            neg_reg  <= base_sel[31] ^ num_v[33] ^ den_v[33];
            zero_reg <= (base_sel == '0) || (num_v == '0) || (den_v == '0);
        end
        if (cmd.mul)
        begin
            quo_reg <= prod_full;
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_diff[32:0] : rem_sh[32:0];
            quo_reg <= {quo_reg[62:0], rem_ge};
        end
        if (cmd.tacc)
        begin
            acc_reg <= acc_reg + term_v;
        end
        if (cmd.tstore)
        begin
            if (k_reg == d_reg)
            begin
                for (int i = 0; i < ROW_DEPTH; i++)
                begin
                    row_reg[i] <= (PW'(i) == k_reg) ? acc_sat : next_reg[i];
                end
                row_prev_reg <= '0;
            end
            else
            begin
                next_reg[k_reg] <= acc_sat;
                row_prev_reg    <= row_reg[0];
                for (int i = 0; i < ROW_DEPTH; i++)
                begin
                    row_reg[i] <= row_shift[i];
                end
            end
        end
        if (cmd.mmul)
        begin
            prod_x_reg <= mul_x;
            prod_y_reg <= mul_y;
        end
        if (cmd.macc)
        begin
            sum_x_reg <= sum_x_reg + $signed(shx[SUM_W-1:0]);
            sum_y_reg <= sum_y_reg + $signed(shy[SUM_W-1:0]);
        end
        if (cmd.macc || cmd.mskip)
        begin
            for (int i = 0; i < ROW_DEPTH; i++)
            begin
                row_reg[i] <= row_shift[i];
            end
        end
        if (cmd.out)
        begin
            curve_x_reg <= sat32(sum_x_reg);
            curve_y_reg <= sat32(sum_y_reg);
        end
    end

    assign done    = done_reg;
    assign curve_x = curve_x_reg;
    assign curve_y = curve_y_reg;
    assign status  = status_reg;

endmodule

@@ rtl/core/bspline_curve_point_eval_top.sv @@
`timescale 1ns / 1ps
// top level of the b-spline curve point evaluator
// depends on bspl_pkg, bspl_ctrl and bspl_dp
//
// usage:
//   commands are taken when start is high and busy is low. knot writes
//   (command 0) and control point writes (command 1) land in the memories
//   at that edge; busy stays low. command 3 is dropped. the receiver
//   cannot stall. an evaluate beat (command 2) raises busy until its
//   result is out. the result stays on curve_x and curve_y until the next
//   output, and on status until the next decision; done marks it and is
//   high for a single cycle. config (degree, point_count, clamped_check)
//   is written through cfg_we, cfg_index and cfg_data; the user must write
//   it only while the block is idle, which the block itself does not enforce.
// sequence of an evaluate, with m = point_count + degree + 1 knots:
//   a knot scan over the m knots and a decision, then for each basis entry
//   each nonzero term runs through the one-bit-per-cycle 64-step divider
//   (a zero term skips it), then a multiply-accumulate per control point
//   in range (skipped otherwise), then the output and done. a failed knot
//   check goes from the decision straight to the output.
// reset puts the config registers at degree 3, point_count 4, no clamp
//   check; memory contents are undefined until written.
module bspline_curve_point_eval_top
    import bspl_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            command,
    input  logic [6:0]            entry_index,
    input  logic [31:0]           knot_value,
    input  logic signed [31:0]    point_x,
    input  logic signed [31:0]    point_y,
    input  logic [31:0]           param_u,
    output logic                  done,
    output logic signed [31:0]    curve_x,
    output logic signed [31:0]    curve_y,
    output logic [1:0]            status,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_WIDTH-1:0]  cfg_data
);

    bspl_cmd_t cmd;
    bspl_sts_t sts;

    // sequencer
    bspl_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy),
        .cmd     (cmd),
        .sts     (sts)
    );

    // datapath
    bspl_dp
    #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DEGREE (MAX_DEGREE)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .entry_index (entry_index),
        .knot_value  (knot_value),
        .point_x     (point_x),
        .point_y     (point_y),
        .param_u     (param_u),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .sts         (sts),
        .done        (done),
        .curve_x     (curve_x),
        .curve_y     (curve_y),
        .status      (status)
    );

endmodule
